// ===== sv/outstanding_command_tracker_defines.svh =====
// Assertion macros shared by the outstanding command tracker RTL.
`ifndef OUTSTANDING_COMMAND_TRACKER_DEFINES_SVH
`define OUTSTANDING_COMMAND_TRACKER_DEFINES_SVH

// Condition that must hold at every clock edge out of reset.
`define OCT_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Consequent that must hold in the cycle after the antecedent.
`define OCT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/oct_pkg.sv =====
// Types and constants for the outstanding command tracker.
package oct_pkg;

  localparam int unsigned PeerW  = 48;
  localparam int unsigned WordW  = 32;
  localparam int unsigned OwnerW = 3;

  // Results per tick scan, and the width of the counter that tracks them
  localparam int unsigned MaxResults = 16;
  localparam int unsigned NumW       = $clog2(MaxResults + 1);

  localparam logic [WordW-1:0] TimeoutReset = 32'd15000;

  // Command codes
  localparam logic [1:0] CMD_ADD  = 2'd0;
  localparam logic [1:0] CMD_TAKE = 2'd1;
  localparam logic [1:0] CMD_TICK = 2'd2;

  // Result status codes
  localparam logic [2:0] ST_ADDED     = 3'd0;
  localparam logic [2:0] ST_FULL      = 3'd1;
  localparam logic [2:0] ST_TAKEN     = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND = 3'd3;
  localparam logic [2:0] ST_EXPIRED   = 3'd4;
  localparam logic [2:0] ST_NONE      = 3'd5;

  // One stored table entry
  typedef struct packed {
    logic [PeerW-1:0]  peer;
    logic [WordW-1:0]  session;
    logic [WordW-1:0]  command;
    logic [WordW-1:0]  stamp;
    logic [OwnerW-1:0] owner;
  } oct_entry_t;

  // Verdict of the slot evaluator for the slot under scan
  typedef struct packed {
    logic take_hit;
    logic expired;
  } oct_eval_t;

endpackage

// ===== sv/oct_ram.sv =====
// Generic simple dual-port RAM with registered read, one write port.
module oct_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                         wdata_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== sv/oct_slot_eval.sv =====
// Shared slot evaluator: take match and age-versus-timeout check for one slot.
module oct_slot_eval (
  input  oct_pkg::oct_entry_t              entry_i,
  input  logic                             slot_valid_i,
  input  logic [oct_pkg::PeerW-1:0]        peer_i,
  input  logic [oct_pkg::WordW-1:0]        session_i,
  input  logic [oct_pkg::WordW-1:0]        command_id_i,
  input  logic [oct_pkg::WordW-1:0]        now_ms_i,
  input  logic [oct_pkg::WordW-1:0]        timeout_ms_i,
  output oct_pkg::oct_eval_t               eval_o
);
  import oct_pkg::*;

  logic [WordW-1:0] age;
  logic             sess_ok;

  // Age wraps modulo 2^32
  assign age     = now_ms_i - entry_i.stamp;
  // Stored session of zero is a wildcard
  assign sess_ok = (entry_i.session == '0) || (entry_i.session == session_i);

  assign eval_o.take_hit = slot_valid_i && (entry_i.peer == peer_i) &&
                           (entry_i.command == command_id_i) && sess_ok;
  assign eval_o.expired  = slot_valid_i && (age >= timeout_ms_i);

endmodule

// ===== sv/outstanding_command_tracker.sv =====
// Outstanding command tracker: slot table with add, take and timeout scan.
//
//  channel | direction | handshake               | words
//  --------+-----------+-------------------------+-------------------------------
//  cfg     | in        | cfg_valid_i/cfg_ready_o | timeout_ms_i
//  in      | in        | in_valid_i/in_ready_o   | cmd, peer, session, id, owner, now
//  out     | out       | out_valid_o/out_ready_i | status, command id, owner, last
//
// Each known command scans the table one slot per cycle through the shared evaluator
// while the output is not stalled: add and take stop at the first hit, tick visits
// every slot up to MaxResults expiries. A new command waits until the last is done.
// The table RAM read port sets the pace. Reset clears the valid bits and loads a 15000 ms timeout.
// A full output register stalls the scan; the config port is always ready.
module outstanding_command_tracker #(
  parameter int unsigned SLOTS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [oct_pkg::WordW-1:0]    timeout_ms_i,
  // input words
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [1:0]                   cmd_i,
  input  logic [oct_pkg::PeerW-1:0]    peer_address_i,
  input  logic [oct_pkg::WordW-1:0]    session_i,
  input  logic [oct_pkg::WordW-1:0]    command_id_i,
  input  logic [oct_pkg::OwnerW-1:0]   owner_tag_i,
  input  logic [oct_pkg::WordW-1:0]    now_ms_i,
  // result words
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [2:0]                   status_o,
  output logic [oct_pkg::WordW-1:0]    result_command_id_o,
  output logic [oct_pkg::OwnerW-1:0]   result_owner_o,
  output logic                         last_o
);
  import oct_pkg::*;

  localparam int unsigned IdxW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(SLOTS - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FLUSH
  } state_e;

  state_e             state_q, state_d;
  logic [IdxW-1:0]    idx_q, idx_d;
  logic [NumW-1:0]    num_q, num_d;
  logic [SLOTS-1:0]   valid_q, valid_d;
  logic               hold_valid_q, hold_valid_d;
  logic [WordW-1:0]   hold_id_q;
  logic [OwnerW-1:0]  hold_owner_q;
  logic               out_valid_q;
  logic [2:0]         status_q;
  logic [WordW-1:0]   res_id_q;
  logic [OwnerW-1:0]  res_owner_q;
  logic               last_q;
  logic [WordW-1:0]   timeout_q;

  // captured input word
  logic [1:0]         cmd_q;
  logic [PeerW-1:0]   peer_q;
  logic [WordW-1:0]   session_q;
  logic [WordW-1:0]   command_id_q;
  logic [OwnerW-1:0]  owner_q;
  logic [WordW-1:0]   now_q;

  logic               capture;
  logic               cmd_known;
  logic               accept_unknown;
  logic               can_put;
  logic               put;
  logic [2:0]         put_status;
  logic [WordW-1:0]   put_id;
  logic [OwnerW-1:0]  put_owner;
  logic               put_last;
  logic               hold_load;
  logic               ram_we;
  logic               at_end;
  oct_entry_t         wr_entry;
  oct_entry_t         rd_entry;
  oct_eval_t          eval;

  // table storage, read address runs one step ahead of the scan index
  oct_ram #(
    .Width ($bits(oct_entry_t)),
    .Depth (SLOTS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (idx_q),
    .wdata_i (wr_entry),
    .raddr_i (idx_d),
    .rdata_o (rd_entry)
  );

  assign wr_entry = '{peer: peer_q, session: session_q, command: command_id_q,
                      stamp: now_q, owner: owner_q};

  oct_slot_eval u_eval (
    .entry_i      (rd_entry),
    .slot_valid_i (valid_q[idx_q]),
    .peer_i       (peer_q),
    .session_i    (session_q),
    .command_id_i (command_id_q),
    .now_ms_i     (now_q),
    .timeout_ms_i (timeout_q),
    .eval_o       (eval)
  );

  assign in_ready_o     = (state_q == S_IDLE);
  assign cfg_ready_o    = 1'b1;
  assign can_put        = !out_valid_q || out_ready_i;
  assign at_end         = (idx_q == LastIdx);
  assign cmd_known      = cmd_i inside {CMD_ADD, CMD_TAKE, CMD_TICK};
  assign accept_unknown = in_valid_i && in_ready_o && !cmd_known;

  // scan sequencer
  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    num_d        = num_q;
    valid_d      = valid_q;
    hold_valid_d = hold_valid_q;
    hold_load    = 1'b0;
    capture      = 1'b0;
    ram_we       = 1'b0;
    put          = 1'b0;
    put_status   = ST_ADDED;
    put_id       = '0;
    put_owner    = '0;
    put_last     = 1'b1;
    case (state_q)
      S_IDLE: begin
        idx_d = '0;
        num_d = '0;
        if (in_valid_i) begin
          capture = 1'b1;
          if (cmd_known) begin
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        case (cmd_q)
          CMD_ADD: begin
            if (!valid_q[idx_q]) begin
              if (can_put) begin
                put            = 1'b1;
                put_status     = ST_ADDED;
                ram_we         = 1'b1;
                valid_d[idx_q] = 1'b1;
                state_d        = S_IDLE;
              end
            end else if (at_end) begin
              if (can_put) begin
                put        = 1'b1;
                put_status = ST_FULL;
                state_d    = S_IDLE;
              end
            end else begin
              idx_d = idx_q + 1'b1;
            end
          end
          CMD_TAKE: begin
            if (eval.take_hit) begin
              if (can_put) begin
                put            = 1'b1;
                put_status     = ST_TAKEN;
                put_id         = rd_entry.command;
                put_owner      = rd_entry.owner;
                valid_d[idx_q] = 1'b0;
                state_d        = S_IDLE;
              end
            end else if (at_end) begin
              if (can_put) begin
                put        = 1'b1;
                put_status = ST_NOT_FOUND;
                state_d    = S_IDLE;
              end
            end else begin
              idx_d = idx_q + 1'b1;
            end
          end
          CMD_TICK: begin
            // an expiry is held back one step so that last can be set on it
            if (eval.expired) begin
              if (!hold_valid_q || can_put) begin
                if (hold_valid_q) begin
                  put        = 1'b1;
                  put_status = ST_EXPIRED;
                  put_id     = hold_id_q;
                  put_owner  = hold_owner_q;
                  put_last   = 1'b0;
                end
                valid_d[idx_q] = 1'b0;
                hold_valid_d   = 1'b1;
                hold_load      = 1'b1;
                num_d          = num_q + 1'b1;
                if (num_q == NumW'(MaxResults - 1) || at_end) begin
                  state_d = S_FLUSH;
                end else begin
                  idx_d = idx_q + 1'b1;
                end
              end
            end else if (at_end) begin
              state_d = S_FLUSH;
            end else begin
              idx_d = idx_q + 1'b1;
            end
          end
          default: begin
            state_d = S_IDLE;
          end
        endcase
      end
      S_FLUSH: begin
        if (can_put) begin
          put          = 1'b1;
          hold_valid_d = 1'b0;
          state_d      = S_IDLE;
          if (hold_valid_q) begin
            put_status = ST_EXPIRED;
            put_id     = hold_id_q;
            put_owner  = hold_owner_q;
          end else begin
            put_status = ST_NONE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      idx_q        <= '0;
      num_q        <= '0;
      valid_q      <= '0;
      hold_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
      timeout_q    <= TimeoutReset;
    end else begin
      state_q      <= state_d;
      idx_q        <= idx_d;
      num_q        <= num_d;
      valid_q      <= valid_d;
      hold_valid_q <= hold_valid_d;
      if (put) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_valid_i) begin
        timeout_q <= timeout_ms_i;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (capture) begin
      cmd_q        <= cmd_i;
      peer_q       <= peer_address_i;
      session_q    <= session_i;
      command_id_q <= command_id_i;
      owner_q      <= owner_tag_i;
      now_q        <= now_ms_i;
    end
    if (hold_load) begin
      hold_id_q    <= rd_entry.command;
      hold_owner_q <= rd_entry.owner;
    end
    if (put) begin
      status_q    <= put_status;
      res_id_q    <= put_id;
      res_owner_q <= put_owner;
      last_q      <= put_last;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign status_o            = status_q;
  assign result_command_id_o = res_id_q;
  assign result_owner_o      = res_owner_q;
  assign last_o              = last_q;

  // checks
  `include "outstanding_command_tracker_defines.svh"

  `OCT_ASSERT_ALWAYS(a_idle_no_hold, !(in_ready_o && hold_valid_q), "held expiry while idle")
  `OCT_ASSERT_ALWAYS(a_hold_only_tick, !hold_valid_q || (cmd_q == CMD_TICK), "hold outside tick")
  `OCT_ASSERT_NEXT(a_unknown_cmd_idle, accept_unknown, in_ready_o && !put, "unknown command ran")

endmodule
